>>> rtl/text_row_cell_mirror_defines.svh
// assertion helpers used by the mirror rtl
`ifndef TEXT_ROW_CELL_MIRROR_DEFINES_SVH
`define TEXT_ROW_CELL_MIRROR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcm_pkg.sv
package tcm_pkg;

  // one stored cell
  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] x;
    logic [7:0] w;
  } cell_t;

  // operation codes
  typedef enum logic [2:0] {
    OP_GLYPH  = 3'd0,
    OP_SCROLL = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_CMD    = 3'd3,
    OP_READ   = 3'd4,
    OP_STALE  = 3'd5
  } op_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_RECORDING  = 1'b0,
    REG_AREA_WIDTH = 1'b1
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_APPEND,
    ST_RD_WAIT,
    ST_RESULT
  } state_t;

  localparam logic [7:0] AREA_WIDTH_RESET = 8'd168;
  localparam int         COUNT_OUT_W      = 6;

endpackage

>>> rtl/tcm_cell_ram.sv
module tcm_cell_ram #(
  parameter int DEPTH  = 120,
  parameter int ADDR_W = 7
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output tcm_pkg::cell_t     rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  tcm_pkg::cell_t     wr_data
);

  tcm_pkg::cell_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/tcm_overlap.sv
module tcm_overlap (
  input  tcm_pkg::cell_t stored,
  input  logic [7:0]     new_x,
  input  logic [7:0]     new_w,
  output logic           hit
);

  logic [8:0] new_end;
  logic [8:0] cell_end;

  // spans compared with 9-bit ends so nothing wraps
  assign new_end  = {1'b0, new_x} + {1'b0, new_w};
  assign cell_end = {1'b0, stored.x} + {1'b0, stored.w};
  assign hit      = ({1'b0, stored.x} < new_end) && ({1'b0, new_x} < cell_end);

endmodule

>>> rtl/text_row_cell_mirror.sv
// channel   direction  handshake                  payload
// input     in         in_valid / in_stall        operation and its operand fields
// output    out        out_valid / out_stall      read cell, row counts, latched flags
// config    in         cfg_write                  cfg_index, cfg_data
//
// a recorded glyph request runs exec, a compaction pass over the cells held in
// its row, then append and result: the compaction pass reads one cell per cycle
// through the single read port of the cell ram and tests it in the one overlap
// unit. a read that hits a cell runs exec, read wait and result, every other
// request exec and result; a new request is taken only back in idle.
// reset clears counts, row rotation, flags and sequencer and holds in_stall high;
// the cell ram is left as is, only entries below a row count are ever read.
// a stalled result holds in the output register while the next request is
// taken; that request finishes once the register is free.
`include "text_row_cell_mirror_defines.svh"

module text_row_cell_mirror #(
  parameter int ROW_COUNT     = 3,
  parameter int CELLS_PER_ROW = 40
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  // request
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] operation,
  input  logic [7:0] glyph_code,
  input  logic [7:0] row_number,
  input  logic [7:0] pen_x,
  input  logic [7:0] glyph_width,
  input  logic [7:0] command_code,
  input  logic       border_drawn,
  input  logic       story_mode,
  input  logic [5:0] cell_index,
  // result
  output logic       out_valid,
  input  logic       out_stall,
  output logic       cell_valid,
  output logic [7:0] cell_glyph,
  output logic [7:0] cell_x,
  output logic [7:0] cell_width,
  output logic [5:0] count_row0,
  output logic [5:0] count_row1,
  output logic [5:0] count_row2,
  output logic [7:0] generation_count,
  output logic [7:0] last_command,
  output logic       bordered_flag,
  output logic       story_flag,
  output logic       stale_flag
);

  localparam int ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CNT_W  = $clog2(CELLS_PER_ROW + 1);
  localparam int IDX_W  = (CELLS_PER_ROW > 1) ? $clog2(CELLS_PER_ROW) : 1;
  localparam int DEPTH  = ROW_COUNT * CELLS_PER_ROW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_OUT_W = tcm_pkg::COUNT_OUT_W;

  tcm_pkg::state_t state, state_next;

  // latched request
  tcm_pkg::op_t item_op;
  logic [7:0]   item_glyph;
  logic [7:0]   item_row;
  logic [7:0]   item_x;
  logic [7:0]   item_w;
  logic [7:0]   item_cmd;
  logic         item_border;
  logic         item_story;
  logic [5:0]   item_idx;

  // configuration
  logic       recording;
  logic [7:0] area_w;

  // mirror state
  logic [CNT_W-1:0] counts [ROW_COUNT];
  logic [ROW_W-1:0] base;
  logic [7:0]       generation;
  logic [7:0]       cmd_latch;
  logic             bordered;
  logic             story;
  logic             stale;

  // compaction pass
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] kept;
  logic [CNT_W-1:0] scan_n;
  logic [ROW_W-1:0] phys_row;

  // read result
  logic       rd_valid;
  logic [7:0] rd_glyph;
  logic [7:0] rd_x;
  logic [7:0] rd_w;
  logic [COUNT_OUT_W-1:0] count_view [3];
  logic [COUNT_OUT_W-1:0] res_count  [3];

  // ram and overlap unit
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  tcm_pkg::cell_t    ram_rd_data;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  tcm_pkg::cell_t    ram_wr_data;
  tcm_pkg::cell_t    new_cell;
  logic              hit;

  // decode of the latched request
  logic [ROW_W-1:0] lrow;
  logic [ROW_W:0]   phys_sum;
  logic [ROW_W-1:0] phys;
  logic             row_ok;
  logic             glyph_go;
  logic             read_ok;
  logic             scan_more;
  logic             room;
  logic             out_free;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [IDX_W-1:0] i);
    cell_addr = ADDR_W'(r) * ADDR_W'(CELLS_PER_ROW) + ADDR_W'(i);
  endfunction

  tcm_cell_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  tcm_overlap u_overlap (
    .stored (ram_rd_data),
    .new_x  (item_x),
    .new_w  (item_w),
    .hit    (hit)
  );

  // logical row to physical row through the scroll rotation
  assign lrow     = item_row[ROW_W-1:0];
  assign phys_sum = {1'b0, lrow} + {1'b0, base};
  assign phys     = (phys_sum >= (ROW_W+1)'(ROW_COUNT)) ?
                    ROW_W'(phys_sum - (ROW_W+1)'(ROW_COUNT)) : ROW_W'(phys_sum);
  assign row_ok   = item_row < 8'(ROW_COUNT);
  assign glyph_go = recording && row_ok && (item_x < area_w);
  assign read_ok  = row_ok && ({1'b0, item_idx} < 7'(counts[lrow]))
                    && ({1'b0, item_idx} < 7'(CELLS_PER_ROW));
  assign scan_more = rd_idx < scan_n;
  assign room      = kept < CNT_W'(CELLS_PER_ROW);
  assign out_free  = !out_valid || !out_stall;
  assign new_cell  = '{glyph: item_glyph, x: item_x, w: item_w};
  assign in_stall  = rst || (state != tcm_pkg::ST_IDLE);

  // visible counts, masked to the output width
  for (genvar r = 0; r < 3; r++) begin : g_view
    if (r < ROW_COUNT) begin : g_row
      logic [7:0] wide;
      assign wide          = 8'(counts[r]);
      assign count_view[r] = wide[COUNT_OUT_W-1:0];
    end else begin : g_none
      assign count_view[r] = '0;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram control
  always_comb begin
    state_next  = state;
    ram_rd_en   = 1'b0;
    ram_rd_addr = cell_addr(phys_row, rd_idx[IDX_W-1:0]);
    ram_wr_en   = 1'b0;
    ram_wr_addr = cell_addr(phys_row, kept[IDX_W-1:0]);
    ram_wr_data = ram_rd_data;
    case (state)
      tcm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tcm_pkg::ST_EXEC;
        end
      end
      tcm_pkg::ST_EXEC: begin
        state_next = tcm_pkg::ST_RESULT;
        if (item_op == tcm_pkg::OP_GLYPH && glyph_go) begin
          ram_rd_addr = cell_addr(phys, '0);
          if (counts[lrow] != '0) begin
            ram_rd_en  = 1'b1;
            state_next = tcm_pkg::ST_SCAN;
          end else begin
            state_next = tcm_pkg::ST_APPEND;
          end
        end else if (item_op == tcm_pkg::OP_READ && read_ok) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = cell_addr(phys, item_idx[IDX_W-1:0]);
          state_next  = tcm_pkg::ST_RD_WAIT;
        end
      end
      tcm_pkg::ST_SCAN: begin
        // survivors are written back at the compacted position
        ram_wr_en = !hit;
        ram_rd_en = scan_more;
        if (!scan_more) begin
          state_next = tcm_pkg::ST_APPEND;
        end
      end
      tcm_pkg::ST_APPEND: begin
        ram_wr_en   = room;
        ram_wr_data = new_cell;
        state_next  = tcm_pkg::ST_RESULT;
      end
      tcm_pkg::ST_RD_WAIT: begin
        state_next = tcm_pkg::ST_RESULT;
      end
      tcm_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = tcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcm_pkg::ST_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state == tcm_pkg::ST_IDLE && in_valid) begin
      item_op     <= tcm_pkg::op_t'(operation);
      item_glyph  <= glyph_code;
      item_row    <= row_number;
      item_x      <= pen_x;
      item_w      <= glyph_width;
      item_cmd    <= command_code;
      item_border <= border_drawn;
      item_story  <= story_mode;
      item_idx    <= cell_index;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      recording <= 1'b0;
      area_w    <= tcm_pkg::AREA_WIDTH_RESET;
    end else if (cfg_write) begin
      case (tcm_pkg::cfg_reg_t'(cfg_index))
        tcm_pkg::REG_RECORDING:  recording <= cfg_data[0];
        tcm_pkg::REG_AREA_WIDTH: area_w    <= cfg_data;
        default: ;
      endcase
    end
  end

  // mirror state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        counts[r] <= '0;
      end
      base       <= '0;
      generation <= '0;
      cmd_latch  <= '0;
      bordered   <= 1'b0;
      story      <= 1'b0;
      stale      <= 1'b0;
    end else begin
      case (state)
        tcm_pkg::ST_EXEC: begin
          case (item_op)
            tcm_pkg::OP_SCROLL: begin
              if (recording) begin
                for (int r = 0; r < ROW_COUNT - 1; r++) begin
                  counts[r] <= counts[r+1];
                end
                counts[ROW_COUNT-1] <= '0;
                base <= (base == ROW_W'(ROW_COUNT - 1)) ? '0 : base + 1'b1;
              end
            end
            tcm_pkg::OP_CLEAR: begin
              if (recording) begin
                for (int r = 0; r < ROW_COUNT; r++) begin
                  counts[r] <= '0;
                end
                cmd_latch  <= '0;
                generation <= generation + 8'd1;
                stale      <= 1'b0;
                bordered   <= item_border;
                story      <= item_story;
              end
            end
            tcm_pkg::OP_CMD: begin
              if (recording) begin
                cmd_latch <= item_cmd;
              end
            end
            tcm_pkg::OP_STALE: begin
              stale <= 1'b1;
            end
            default: ;
          endcase
        end
        tcm_pkg::ST_APPEND: begin
          counts[lrow] <= room ? kept + 1'b1 : kept;
        end
        default: ;
      endcase
    end
  end

  // compaction pass counters and read result
  always_ff @(posedge clk) begin
    case (state)
      tcm_pkg::ST_EXEC: begin
        rd_valid <= 1'b0;
        rd_glyph <= '0;
        rd_x     <= '0;
        rd_w     <= '0;
        phys_row <= phys;
        scan_n   <= counts[lrow];
        kept     <= '0;
        rd_idx   <= (counts[lrow] != '0) ? CNT_W'(1) : '0;
      end
      tcm_pkg::ST_SCAN: begin
        if (!hit) begin
          kept <= kept + 1'b1;
        end
        if (scan_more) begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      tcm_pkg::ST_RD_WAIT: begin
        rd_valid <= 1'b1;
        rd_glyph <= ram_rd_data.glyph;
        rd_x     <= ram_rd_data.x;
        rd_w     <= ram_rd_data.w;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tcm_pkg::ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcm_pkg::ST_RESULT && out_free) begin
      cell_valid       <= rd_valid;
      cell_glyph       <= rd_glyph;
      cell_x           <= rd_x;
      cell_width       <= rd_w;
      res_count[0]     <= count_view[0];
      res_count[1]     <= count_view[1];
      res_count[2]     <= count_view[2];
      generation_count <= generation;
      last_command     <= cmd_latch;
      bordered_flag    <= bordered;
      story_flag       <= story;
      stale_flag       <= stale;
    end
  end

  assign count_row0 = res_count[0];
  assign count_row1 = res_count[1];
  assign count_row2 = res_count[2];

  // checks
  `TCM_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state != tcm_pkg::ST_IDLE, "request accepted without work")
  `TCM_ASSERT_NOW(a_scan_order, state == tcm_pkg::ST_SCAN, kept < rd_idx, "compaction write passed read")
  `TCM_ASSERT_NOW(a_scan_bound, state == tcm_pkg::ST_SCAN, rd_idx <= scan_n, "scan ran past row count")
  `TCM_ASSERT_NOW(a_base_range, 1'b1, base < ROW_W'(ROW_COUNT - 1) || base == ROW_W'(ROW_COUNT - 1), "row rotation out of range")
  `TCM_ASSERT_NOW(a_wr_glyph, ram_wr_en, item_op == tcm_pkg::OP_GLYPH, "cell write outside glyph request")

endmodule
